### hdl/sdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stroke direction classifier.
// No dependencies; imported by sdc_step and stroke_direction_classifier_top.
package sdc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SUM_BITS_DEF   = 32;
  localparam int unsigned NUM_DIRS       = 4;
  localparam int unsigned SENS_BITS      = 16;

  localparam logic [SENS_BITS-1:0] SENS_RESET = 16'd15;
  localparam logic [SENS_BITS-1:0] SENS_MIN   = 16'd2;

  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_X_NEG = 3'd1,
    DIR_X_POS = 3'd2,
    DIR_Y_NEG = 3'd3,
    DIR_Y_POS = 3'd4
  } dir_e;

  // Direction history carried from one item to the next.
  typedef struct packed {
    dir_e dir;
    logic changed;
  } dir_state_t;

endpackage

### hdl/stroke_direction_classifier_top.sv
`timescale 1ns / 1ps
// Top level of the stroke direction classifier: input stage, state, result stage.
// Depends on sdc_pkg and sdc_step.
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  ------------------------------------------
//   input     in_valid_i / in_stall_o      mode_i, x_coord_i, y_coord_i
//   result    out_valid_o / out_stall_i    direction_o, direction_changed_o,
//                                          held_x_o, held_y_o
//   config    sens_we_i                    sens_wdata_i
//
// An item is held in the input register and moves into the result register when the
// result side is free, so its result is registered there; one item per cycle is
// sustained while the result is not stalled.
// The state is updated as the item moves into the result register.
// Reset clears the state and loads the sensitivity with 15. When the result is
// stalled the input register still holds one item before the input side stalls.
module stroke_direction_classifier_top #(
  parameter int unsigned COORD_BITS = sdc_pkg::COORD_BITS_DEF,
  parameter int unsigned SUM_BITS   = sdc_pkg::SUM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sens_we_i,
  input  logic [sdc_pkg::SENS_BITS-1:0]  sens_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic signed [COORD_BITS-1:0]   x_coord_i,
  input  logic signed [COORD_BITS-1:0]   y_coord_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     direction_o,
  output logic                           direction_changed_o,
  output logic signed [COORD_BITS-1:0]   held_x_o,
  output logic signed [COORD_BITS-1:0]   held_y_o
);
  import sdc_pkg::*;

  logic                         in_vld_q, in_vld_d;
  logic                         in_mode_q;
  logic signed [COORD_BITS-1:0] in_x_q, in_y_q;
  logic                         out_vld_q, out_vld_d;
  logic [SENS_BITS-1:0]         sens_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_x_d, prev_y_d;
  logic [SUM_BITS-1:0]          sums_q [NUM_DIRS];
  logic [SUM_BITS-1:0]          sums_d [NUM_DIRS];
  dir_state_t                   hist_q, hist_d;
  dir_e                         step_dir;
  dir_e                         dir_q;
  logic                         accept, advance;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d  = advance ? 1'b1 : ((out_vld_q && out_stall_i) ? 1'b1 : 1'b0);

  sdc_step #(
    .COORD_BITS(COORD_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_step (
    .mode_i  (in_mode_q),
    .x_i     (in_x_q),
    .y_i     (in_y_q),
    .prev_x_i(prev_x_q),
    .prev_y_i(prev_y_q),
    .sums_i  (sums_q),
    .sens_i  (sens_q),
    .hist_i  (hist_q),
    .prev_x_o(prev_x_d),
    .prev_y_o(prev_y_d),
    .sums_o  (sums_d),
    .hist_o  (hist_d),
    .dir_o   (step_dir)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      sens_q    <= SENS_RESET;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      hist_q    <= '{dir: DIR_NONE, changed: 1'b0};
      for (int i = 0; i < NUM_DIRS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (sens_we_i && (sens_wdata_i >= SENS_MIN)) begin
        sens_q <= sens_wdata_i;
      end
      if (advance) begin
        prev_x_q <= prev_x_d;
        prev_y_q <= prev_y_d;
        hist_q   <= hist_d;
        for (int i = 0; i < NUM_DIRS; i++) begin
          sums_q[i] <= sums_d[i];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q <= mode_i;
      in_x_q    <= x_coord_i;
      in_y_q    <= y_coord_i;
    end
    if (advance) begin
      dir_q               <= step_dir;
      direction_changed_o <= hist_d.changed;
      held_x_o            <= prev_x_d;
      held_y_o            <= prev_y_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign direction_o = dir_q;

  // The changed flag is only ever set together with a recognized direction.
  a_changed_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_q.changed |-> (hist_q.dir != DIR_NONE))
    else $error("changed flag set without a recognized direction");

  // A begin transfer reports no direction and holds its own point.
  a_begin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_mode_q == MODE_BEGIN)) |=>
      (dir_q == DIR_NONE) && !direction_changed_o &&
      (held_x_o == $past(in_x_q)) && (held_y_o == $past(in_y_q)))
    else $error("begin item result mismatch");

  // The input side stalls only when both stages are full and the result is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // The sensitivity never drops below its minimum.
  a_sens_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sens_q >= SENS_MIN)
    else $error("sensitivity below minimum");

endmodule

### hdl/sdc_step.sv
`timescale 1ns / 1ps
// Combinational update of the classifier state for one item.
// Depends on sdc_pkg for the direction codes and the history struct.
module sdc_step #(
  parameter int unsigned COORD_BITS = sdc_pkg::COORD_BITS_DEF,
  parameter int unsigned SUM_BITS   = sdc_pkg::SUM_BITS_DEF
) (
  input  logic                                mode_i,
  input  logic signed [COORD_BITS-1:0]        x_i,
  input  logic signed [COORD_BITS-1:0]        y_i,
  input  logic signed [COORD_BITS-1:0]        prev_x_i,
  input  logic signed [COORD_BITS-1:0]        prev_y_i,
  input  logic [SUM_BITS-1:0]                 sums_i [sdc_pkg::NUM_DIRS],
  input  logic [sdc_pkg::SENS_BITS-1:0]       sens_i,
  input  sdc_pkg::dir_state_t                 hist_i,
  output logic signed [COORD_BITS-1:0]        prev_x_o,
  output logic signed [COORD_BITS-1:0]        prev_y_o,
  output logic [SUM_BITS-1:0]                 sums_o [sdc_pkg::NUM_DIRS],
  output sdc_pkg::dir_state_t                 hist_o,
  output sdc_pkg::dir_e                       dir_o
);
  import sdc_pkg::*;

  localparam int unsigned AbsW = COORD_BITS + 1;
  localparam int unsigned AddW = ((SUM_BITS > AbsW) ? SUM_BITS : AbsW) + 1;
  localparam logic [SUM_BITS-1:0] SumMax = {SUM_BITS{1'b1}};

  logic signed [AbsW-1:0] dx, dy;
  logic [AbsW-1:0]        ax, ay, mag;
  logic                   x_major;
  logic [1:0]             cur;
  logic [AddW-1:0]        wide;
  logic [SUM_BITS-1:0]    sat;
  logic [SUM_BITS-1:0]    sens_ext;
  logic [SUM_BITS-1:0]    upd [NUM_DIRS];
  logic                   hit;
  dir_e                   first_dir;
  dir_e                   point_dir;

  assign dx = {x_i[COORD_BITS-1], x_i} - {prev_x_i[COORD_BITS-1], prev_x_i};
  assign dy = {y_i[COORD_BITS-1], y_i} - {prev_y_i[COORD_BITS-1], prev_y_i};
  assign ax = dx[AbsW-1] ? AbsW'(-dx) : AbsW'(dx);
  assign ay = dy[AbsW-1] ? AbsW'(-dy) : AbsW'(dy);

  // A tie between the axes goes to Y.
  assign x_major = ax > ay;
  assign cur     = x_major ? (dx[AbsW-1] ? 2'd0 : 2'd1) : (dy[AbsW-1] ? 2'd2 : 2'd3);
  assign mag     = x_major ? ax : ay;

  assign wide     = AddW'(sums_i[cur]) + AddW'(mag);
  assign sat      = (wide > AddW'(SumMax)) ? SumMax : wide[SUM_BITS-1:0];
  assign sens_ext = SUM_BITS'(sens_i);
  assign hit      = sat > sens_ext;

  always_comb begin
    int i;
    first_dir = DIR_NONE;
    for (i = NUM_DIRS - 1; i >= 0; i--) begin
      upd[i] = (2'(i) == cur) ? sat : sums_i[i];
      // Walking downward leaves the lowest code that is over the threshold.
      if (upd[i] > sens_ext) begin
        first_dir = dir_e'(3'(i) + 3'd1);
      end
    end
    point_dir = hit ? dir_e'({1'b0, cur} + 3'd1) : first_dir;
  end

  always_comb begin
    int i;
    prev_x_o = prev_x_i;
    prev_y_o = prev_y_i;
    hist_o   = hist_i;
    dir_o    = DIR_NONE;
    for (i = 0; i < NUM_DIRS; i++) begin
      sums_o[i] = sums_i[i];
    end
    if (mode_i == MODE_BEGIN) begin
      prev_x_o = x_i;
      prev_y_o = y_i;
      hist_o   = '{dir: DIR_NONE, changed: 1'b0};
      for (i = 0; i < NUM_DIRS; i++) begin
        sums_o[i] = '0;
      end
    end else if (prev_x_i != '0 || prev_y_i != '0) begin
      // A point taken while the held point is the origin leaves everything as is.
      prev_x_o = x_i;
      prev_y_o = y_i;
      dir_o    = point_dir;
      hist_o   = '{dir: point_dir,
                   changed: (point_dir != DIR_NONE) && (point_dir != hist_i.dir)};
      for (i = 0; i < NUM_DIRS; i++) begin
        sums_o[i] = (hit && (2'(i) != cur)) ? '0 : upd[i];
      end
    end
  end

endmodule

### test/stroke_direction_classifier_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stroke_direction_classifier_top: predicts every result and compares.
// Depends on sdc_pkg and the classifier RTL; needs no files or arguments.
module stroke_direction_classifier_top_tb;
  import sdc_pkg::*;

  localparam int unsigned CW = COORD_BITS_DEF;
  localparam longint unsigned TRAVEL_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic          mode;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } stroke_item_t;

  typedef struct {
    dir_e          dir;
    logic          changed;
    logic [CW-1:0] hx;
    logic [CW-1:0] hy;
  } stroke_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 sens_we_i = 1'b0;
  logic [SENS_BITS-1:0] sens_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i = MODE_BEGIN;
  logic [CW-1:0]        x_coord_i = '0;
  logic [CW-1:0]        y_coord_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           direction_o;
  logic                 direction_changed_o;
  logic [CW-1:0]        held_x_o;
  logic [CW-1:0]        held_y_o;

  stroke_item_t   stroke_q[$];
  stroke_result_t predicted_q[$];
  int             err_cnt = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             phase_id = 0;
  logic           hold_on = 1'b0;

  // Predictor state.
  logic [SENS_BITS-1:0] sens_model;
  logic [CW-1:0]        hold_x;
  logic [CW-1:0]        hold_y;
  longint unsigned      travel[NUM_DIRS];
  dir_e                 last_dir;
  logic                 chg_flag;

  stroke_direction_classifier_top #(
    .COORD_BITS(CW),
    .SUM_BITS  (SUM_BITS_DEF)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sens_we_i          (sens_we_i),
    .sens_wdata_i       (sens_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .direction_o        (direction_o),
    .direction_changed_o(direction_changed_o),
    .held_x_o           (held_x_o),
    .held_y_o           (held_y_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_stroke();
    hold_x = '0;
    hold_y = '0;
    for (int i = 0; i < NUM_DIRS; i++) travel[i] = 0;
    last_dir = DIR_NONE;
    chg_flag = 1'b0;
  endfunction

  function automatic longint unsigned add_travel(longint unsigned a, longint unsigned b);
    if (a >= TRAVEL_MAX || b >= TRAVEL_MAX - a) return TRAVEL_MAX;
    return a + b;
  endfunction

  // Updates the stroke state for one accepted transfer and queues the result it must give.
  function automatic void classify_item(logic mode, logic [CW-1:0] x, logic [CW-1:0] y);
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    int              cur;
    dir_e            got_dir;
    stroke_result_t  r;
    got_dir = DIR_NONE;
    if (mode == MODE_BEGIN) begin
      clear_stroke();
      hold_x = x;
      hold_y = y;
    end else if (hold_x != '0 || hold_y != '0) begin
      dx = longint'($signed(x)) - longint'($signed(hold_x));
      dy = longint'($signed(y)) - longint'($signed(hold_y));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // Equal travel on both axes counts as vertical.
      if (ax > ay) begin
        cur = (dx < 0) ? 0 : 1;
        travel[cur] = add_travel(travel[cur], ax);
      end else begin
        cur = (dy < 0) ? 2 : 3;
        travel[cur] = add_travel(travel[cur], ay);
      end
      hold_x = x;
      hold_y = y;
      if (travel[cur] > sens_model) begin
        for (int i = 0; i < NUM_DIRS; i++) if (i != cur) travel[i] = 0;
        got_dir = dir_e'(cur + 1);
      end else begin
        // Scanning downward leaves the lowest direction code that is over the threshold.
        for (int i = NUM_DIRS - 1; i >= 0; i--)
          if (travel[i] > sens_model) got_dir = dir_e'(i + 1);
      end
      chg_flag = (got_dir != DIR_NONE && got_dir != last_dir);
      last_dir = got_dir;
    end
    r.dir = got_dir;
    r.changed = chg_flag;
    r.hx = hold_x;
    r.hy = hold_y;
    predicted_q.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : drive_items
    stroke_item_t nxt;
    if (in_valid_i && !in_stall_o) classify_item(mode_i, x_coord_i, y_coord_i);
    if (!in_valid_i || !in_stall_o) begin
      if (stroke_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stroke_q.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= nxt.mode;
        x_coord_i <= nxt.x;
        y_coord_i <= nxt.y;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    stroke_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (predicted_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected transfer: expected none, actual dir %0d", $time,
                 direction_o);
      end else begin
        want = predicted_q.pop_front();
        if (direction_o !== want.dir) flag_mismatch("direction", want.dir, direction_o);
        if (direction_changed_o !== want.changed)
          flag_mismatch("direction_changed", want.changed, direction_changed_o);
        if (held_x_o !== want.hx) flag_mismatch("held_x", want.hx, held_x_o);
        if (held_y_o !== want.hy) flag_mismatch("held_y", want.hy, held_y_o);
      end
    end
    out_stall_i <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off so the input side fills up and has to stall.
  initial begin : hold_off
    int n;
    wait (phase_id == 1);
    repeat (20) @(posedge clk_i);
    hold_on <= 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_item(logic mode, logic [CW-1:0] x, logic [CW-1:0] y);
    stroke_item_t it;
    it.mode = mode;
    it.x = x;
    it.y = y;
    stroke_q.push_back(it);
  endtask

  task automatic settle();
    while (stroke_q.size() != 0 || in_valid_i || predicted_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sens(logic [SENS_BITS-1:0] v);
    @(posedge clk_i);
    sens_we_i <= 1'b1;
    sens_wdata_i <= v;
    @(posedge clk_i);
    sens_we_i <= 1'b0;
    if (v >= SENS_MIN) sens_model = v;
    @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[CW-1:0];
  endfunction

  // Mostly well-formed strokes with a drifting main direction, plus some raw noise.
  task automatic gen_strokes(int count);
    int     made;
    int     pts;
    int     heading;
    longint px;
    longint py;
    longint mag_hi;
    longint run;
    longint side;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(3) == 0) push_item(1'($urandom_range(1)), '0, '0);
        else push_item(1'($urandom_range(1)), CW'($urandom), CW'($urandom));
        made++;
      end else begin
        px = longint'($signed(16'($urandom)));
        py = longint'($signed(16'($urandom)));
        if ($urandom_range(9) == 0) begin
          px = 0;
          py = 0;
        end
        push_item(MODE_BEGIN, px[CW-1:0], py[CW-1:0]);
        made++;
        case ($urandom_range(2))
          0: mag_hi = 6;
          1: mag_hi = 200;
          default: mag_hi = 65535;
        endcase
        heading = $urandom_range(3);
        pts = $urandom_range(2, 16);
        for (int k = 0; k < pts; k++) begin
          if ($urandom_range(4) == 0) heading = $urandom_range(3);
          run = $urandom_range(mag_hi);
          side = ($urandom_range(7) == 0) ? run : $urandom_range(run / 2 + 1);
          if ($urandom_range(1)) side = -side;
          if (heading[0] == 1'b0) run = -run;
          if (heading < 2) begin
            px = clamp_coord(px + run);
            py = clamp_coord(py + side);
          end else begin
            px = clamp_coord(px + side);
            py = clamp_coord(py + run);
          end
          px = longint'($signed(px[CW-1:0]));
          py = longint'($signed(py[CW-1:0]));
          push_item(MODE_POINT, px[CW-1:0], py[CW-1:0]);
          made++;
        end
      end
    end
  endtask

  initial begin : run_test
    sens_model = SENS_RESET;
    clear_stroke();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A point with the held point at the origin is ignored, both after reset and after a begin.
    push_item(MODE_POINT, 16'd100, 16'd100);
    push_item(MODE_BEGIN, 16'h0000, 16'h0000);
    push_item(MODE_POINT, 16'd5, 16'd5);
    // Full-scale moves along each axis, then a diagonal tie that goes to Y.
    push_item(MODE_BEGIN, 16'h8000, 16'h8000);
    push_item(MODE_POINT, 16'h7FFF, 16'h8000);
    push_item(MODE_POINT, 16'h7FFF, 16'h7FFF);
    push_item(MODE_POINT, 16'h8000, 16'h8000);
    push_item(MODE_POINT, 16'h8000, 16'h8000);
    // Returning to the origin mid-stroke freezes the stroke.
    push_item(MODE_POINT, 16'h0000, 16'h0000);
    push_item(MODE_POINT, 16'd10, 16'd10);
    push_item(MODE_BEGIN, 16'd1, 16'd0);
    push_item(MODE_POINT, -16'sd20, 16'd0);
    push_item(MODE_POINT, -16'sd25, 16'd2);
    push_item(MODE_BEGIN, 16'd1, 16'd1);
    push_item(MODE_POINT, 16'd3, 16'd1);
    push_item(MODE_POINT, 16'd3, -16'sd30);
    settle();

    // Writes below the minimum leave the threshold at its reset value.
    write_sens(16'd0);
    write_sens(16'd1);
    push_item(MODE_BEGIN, 16'd0, 16'd5);
    push_item(MODE_POINT, 16'd0, 16'd20);
    push_item(MODE_POINT, 16'd0, 16'd21);
    push_item(MODE_POINT, 16'd0, 16'd21);
    settle();

    write_sens(SENS_MIN);
    phase_id = 1;
    gen_strokes(300);
    settle();

    write_sens(16'hFFFF);
    send_idle_pct <= 82;
    gen_strokes(250);
    settle();

    write_sens(16'($urandom_range(16, 400)));
    send_idle_pct <= 0;
    recv_stall_pct <= 82;
    gen_strokes(250);
    settle();

    write_sens(16'd40);
    send_idle_pct <= 8;
    recv_stall_pct <= 8;
    gen_strokes(250);
    settle();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
